### hw/rtl/sobet_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge threshold package
// Word types, register indexes and fixed constants shared by the block.
// ----------------------------------------------------------------------------
package sobet_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [7:0]  edge_value;
        logic [10:0] center_column;
        logic [10:0] center_row;
        logic        frame_done;
    } t_result;

    typedef struct packed {
        logic        emit;
        logic        border;
        logic        done;
        logic [10:0] cc;
        logic [10:0] cr;
    } t_meta;

    localparam logic [1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_EDGE_THRESHOLD = 2'd2;

    localparam logic [11:0] RST_FRAME_WIDTH  = 12'd640;
    localparam logic [11:0] RST_FRAME_HEIGHT = 12'd480;
    localparam logic [7:0]  RST_THRESHOLD    = 8'd100;
    localparam logic [7:0]  THRESHOLD_OFF    = 8'd255;

    localparam logic [19:0] GRAY_RECIP = 20'd683;

    localparam logic [7:0] EDGE_ON  = 8'hFF;
    localparam logic [7:0] EDGE_OFF = 8'h00;

    localparam int OUT_FIFO_DEPTH = 8;
    localparam int OUT_FIFO_AW    = 3;

endpackage

### hw/rtl/sobet_stream_if.sv
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface sobet_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/sobet_line_store.sv
// ----------------------------------------------------------------------------
// Line store
// Both previous rows packed per column, one read and one write per cycle,
// registered read data.
// ----------------------------------------------------------------------------
module sobet_line_store #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [15:0]   o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [15:0]   i_wr_data
);
    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

### hw/rtl/sobet_kernel.sv
// ----------------------------------------------------------------------------
// Sobel kernel
// Takes line store data, writes the rows back, shifts the window and runs
// gradient, square and threshold stages.
// ----------------------------------------------------------------------------
module sobet_kernel #(
    parameter int AW = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  logic [7:0]            i_gray,
    input  logic [AW-1:0]         i_addr,
    input  sobet_pkg::t_meta      i_meta,
    input  logic [15:0]           i_rd_data,
    output logic                  o_wr_en,
    output logic [AW-1:0]         o_wr_addr,
    output logic [15:0]           o_wr_data,
    input  logic [16:0]           i_thr_sq,
    input  logic                  i_thr_en,
    output logic [1:0]            o_inflight,
    output logic                  o_push,
    output sobet_pkg::t_result    o_result
);
    import sobet_pkg::*;

    logic          r_b_vld, r_c_vld, r_d_vld;
    logic [7:0]    r_b_gray;
    logic [AW-1:0] r_b_addr;
    t_meta         r_b_meta, r_c_meta, r_d_meta;
    logic [7:0]    r_win [6];
    logic signed [10:0] r_c_gx, r_c_gy;
    logic [19:0]   r_d_sqx, r_d_sqy;

    logic [7:0]    w_top, w_mid;
    logic [9:0]    w_sx_hi, w_sx_lo, w_sy_hi, w_sy_lo;
    logic signed [10:0] n_gx, n_gy;
    logic signed [21:0] w_px, w_py;
    logic [20:0]   w_mag;

    assign w_top = i_rd_data[15:8];
    assign w_mid = i_rd_data[7:0];

    assign w_sx_hi = 10'(w_top) + {1'b0, w_mid, 1'b0} + 10'(r_b_gray);
    assign w_sx_lo = 10'(r_win[0]) + {1'b0, r_win[1], 1'b0} + 10'(r_win[2]);
    assign w_sy_hi = 10'(r_win[2]) + {1'b0, r_win[5], 1'b0} + 10'(r_b_gray);
    assign w_sy_lo = 10'(r_win[0]) + {1'b0, r_win[3], 1'b0} + 10'(w_top);
    assign n_gx = $signed({1'b0, w_sx_hi}) - $signed({1'b0, w_sx_lo});
    assign n_gy = $signed({1'b0, w_sy_hi}) - $signed({1'b0, w_sy_lo});

    assign o_wr_en   = r_b_vld;
    assign o_wr_addr = r_b_addr;
    assign o_wr_data = {w_mid, r_b_gray};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= 8'd0;
            end
        end else begin
            r_b_vld <= i_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            if (r_b_vld) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= w_top;
                r_win[4] <= w_mid;
                r_win[5] <= r_b_gray;
            end
        end
    end

    assign w_px = r_c_gx * r_c_gx;
    assign w_py = r_c_gy * r_c_gy;

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_b_gray <= i_gray;
            r_b_addr <= i_addr;
            r_b_meta <= i_meta;
        end
        if (r_b_vld) begin
            r_c_gx   <= n_gx;
            r_c_gy   <= n_gy;
            r_c_meta <= r_b_meta;
        end
        if (r_c_vld) begin
            r_d_sqx  <= w_px[19:0];
            r_d_sqy  <= w_py[19:0];
            r_d_meta <= r_c_meta;
        end
    end

    assign w_mag      = 21'(r_d_sqx) + 21'(r_d_sqy);
    assign o_inflight = 2'(r_b_vld) + 2'(r_c_vld) + 2'(r_d_vld);
    assign o_push     = r_d_vld && r_d_meta.emit;

    always_comb begin
        o_result.edge_value    = EDGE_OFF;
        if (!r_d_meta.border && i_thr_en && (w_mag >= 21'(i_thr_sq))) begin
            o_result.edge_value = EDGE_ON;
        end
        o_result.center_column = r_d_meta.cc;
        o_result.center_row    = r_d_meta.cr;
        o_result.frame_done    = r_d_meta.done;
    end
endmodule

### hw/rtl/sobet_out_fifo.sv
// ----------------------------------------------------------------------------
// Output queue
// Small result queue that decouples the kernel from the output channel.
// ----------------------------------------------------------------------------
module sobet_out_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  sobet_pkg::t_result    i_data,
    output logic [sobet_pkg::OUT_FIFO_AW:0] o_count,
    sobet_stream_if.source        o_result
);
    import sobet_pkg::*;

    t_result                r_mem [OUT_FIFO_DEPTH];
    logic [OUT_FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [OUT_FIFO_AW:0]   r_count;
    logic                   w_pop;

    assign w_pop = o_result.valid && o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (OUT_FIFO_AW+1)'(i_push) - (OUT_FIFO_AW+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_result.valid   = (r_count != '0);
    assign o_result.payload = r_mem[r_rd_ptr];
    assign o_count          = r_count;
endmodule

### hw/rtl/sobel_edge_threshold_top.sv
// A result passes kernel registers B, C and D, then the output queue, before it is offered.
// Throughput: one pixel word per cycle; ready drops only while the output
// queue and the three kernel stages together hold eight words.
// Reset: counters, window, pipeline valids and registers return to defaults;
// line stores are not cleared, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
// Sobel edge threshold top
// Gray conversion, raster counters, config registers and line store access.
// ----------------------------------------------------------------------------
module sobel_edge_threshold_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [11:0]           i_cfg_wdata,
    sobet_stream_if.sink          i_pixel,
    sobet_stream_if.source        o_result
);
    import sobet_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int HW  = $clog2(MAX_HEIGHT);
    localparam int WW  = AW + 1;
    localparam int HHW = HW + 1;

    logic [11:0]   r_cfg_width, r_cfg_height;
    logic [16:0]   r_thr_sq;
    logic          r_thr_en;
    logic [AW-1:0] r_col, n_col;
    logic [HW-1:0] r_row, n_row;

    logic [WW-1:0]  w_width;
    logic [HHW-1:0] w_height;
    logic           w_last_col, w_last_row, w_acc;
    logic [9:0]     w_sum;
    logic [19:0]    w_prod;
    logic [7:0]     w_gray;
    t_meta          w_meta;
    logic [17:0]    w_thr_prod;
    logic [8:0]     w_thr_p1;

    logic [15:0]    w_rd_data;
    logic           w_wr_en;
    logic [AW-1:0]  w_wr_addr;
    logic [15:0]    w_wr_data;
    logic [1:0]     w_inflight;
    logic           w_push;
    t_result        w_result;
    logic [OUT_FIFO_AW:0] w_fifo_count;
    logic [OUT_FIFO_AW+1:0] w_credit;

    assign w_thr_p1   = 9'(i_cfg_wdata[7:0]) + 9'd1;
    assign w_thr_prod = 18'(w_thr_p1) * 18'(w_thr_p1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RST_FRAME_WIDTH;
            r_cfg_height <= RST_FRAME_HEIGHT;
            r_thr_sq     <= 17'((18'(RST_THRESHOLD) + 18'd1) * (18'(RST_THRESHOLD) + 18'd1));
            r_thr_en     <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH: begin
                    r_cfg_width <= i_cfg_wdata;
                end
                CFG_FRAME_HEIGHT: begin
                    r_cfg_height <= i_cfg_wdata;
                end
                CFG_EDGE_THRESHOLD: begin
                    r_thr_sq <= w_thr_prod[16:0];
                    r_thr_en <= (i_cfg_wdata[7:0] != THRESHOLD_OFF);
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_cfg_width < 12'd3) begin
            w_width = WW'(3);
        end else if ({20'd0, r_cfg_width} > 32'(MAX_WIDTH)) begin
            w_width = WW'(MAX_WIDTH);
        end else begin
            w_width = WW'(r_cfg_width);
        end
        if (r_cfg_height < 12'd3) begin
            w_height = HHW'(3);
        end else if ({20'd0, r_cfg_height} > 32'(MAX_HEIGHT)) begin
            w_height = HHW'(MAX_HEIGHT);
        end else begin
            w_height = HHW'(r_cfg_height);
        end
    end

    assign w_credit      = (OUT_FIFO_AW+2)'(w_fifo_count) + (OUT_FIFO_AW+2)'(w_inflight);
    assign i_pixel.ready = (w_credit < (OUT_FIFO_AW+2)'(OUT_FIFO_DEPTH));
    assign w_acc         = i_pixel.valid && i_pixel.ready;

    assign w_last_col = ((WW'(r_col) + 1'b1) >= w_width);
    assign w_last_row = ((HHW'(r_row) + 1'b1) >= w_height);

    assign w_sum  = 10'(i_pixel.payload.red) + 10'(i_pixel.payload.green)
                  + 10'(i_pixel.payload.blue);
    assign w_prod = 20'(w_sum) * GRAY_RECIP;
    assign w_gray = w_prod[18:11];

    always_comb begin
        w_meta.emit   = (r_col != '0) && (r_row != '0);
        w_meta.border = (r_col <= AW'(1)) || (r_row <= HW'(1));
        w_meta.done   = w_last_col && w_last_row;
        w_meta.cc     = 11'(r_col - 1'b1);
        w_meta.cr     = 11'(r_row - 1'b1);
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_acc) begin
            if (w_last_col) begin
                n_col = '0;
                n_row = w_last_row ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    sobet_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_acc),
        .i_rd_addr (r_col),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    sobet_kernel #(
        .AW (AW)
    ) u_kernel (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (w_acc),
        .i_gray     (w_gray),
        .i_addr     (r_col),
        .i_meta     (w_meta),
        .i_rd_data  (w_rd_data),
        .o_wr_en    (w_wr_en),
        .o_wr_addr  (w_wr_addr),
        .o_wr_data  (w_wr_data),
        .i_thr_sq   (r_thr_sq),
        .i_thr_en   (r_thr_en),
        .o_inflight (w_inflight),
        .o_push     (w_push),
        .o_result   (w_result)
    );

    sobet_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_result),
        .o_count  (w_fifo_count),
        .o_result (o_result)
    );

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_wr_en) |-> (r_col != w_wr_addr))
        else $error("line store read and write hit the same column");

    a_fifo_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_fifo_count < (OUT_FIFO_AW+1)'(OUT_FIFO_DEPTH)))
        else $error("output queue overflow");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_last_col && w_last_row) |=> (r_col == '0 && r_row == '0))
        else $error("counters did not wrap at end of frame");

endmodule

### tb/sv/sobel_edge_threshold_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sobel edge threshold checker
// Watches the register port and both stream channels, keeps its own copy of
// the line stores, window and raster position, predicts the edge word for every accepted
// pixel with nonzero row and column and compares each accepted result word in order.
// ----------------------------------------------------------------------------
module sobel_edge_threshold_checker #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [11:0]         i_cfg_wdata,
    input  logic                i_pix_valid,
    input  logic                i_pix_ready,
    input  sobet_pkg::t_pixel   i_pix,
    input  logic                i_res_valid,
    input  logic                i_res_ready,
    input  sobet_pkg::t_result  i_res,
    output int                  o_mismatch_count,
    output int                  o_pending_count
);
    import sobet_pkg::*;

    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic [7:0]  thresh_reg;

    logic [7:0]  row_one_gray [MAX_WIDTH];
    logic [7:0]  row_two_gray [MAX_WIDTH];
    logic [7:0]  win_gray [6];
    int unsigned col_pos;
    int unsigned row_pos;

    t_result     expected_edges [$];

    task automatic predict_edge(input t_pixel px);
        int unsigned w, h, c, r, idx, t1, mag;
        int          top, mid, bot, gx, gy;
        logic        last_col, last_row;
        t_result     res;
        w = (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        h = (height_reg < 3) ? 3 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        c = col_pos;
        r = row_pos;
        idx = (c < MAX_WIDTH) ? c : 0;
        top = int'(row_two_gray[idx]);
        mid = int'(row_one_gray[idx]);
        bot = (int'(px.red) + int'(px.green) + int'(px.blue)) / 3;
        last_col = (c + 1 >= w);
        last_row = (r + 1 >= h);
        if (c >= 1 && r >= 1) begin
            res.edge_value = EDGE_OFF;
            if (c >= 2 && r >= 2) begin
                gx = (top + 2 * mid + bot)
                   - (int'(win_gray[0]) + 2 * int'(win_gray[1]) + int'(win_gray[2]));
                gy = (int'(win_gray[2]) + 2 * int'(win_gray[5]) + bot)
                   - (int'(win_gray[0]) + 2 * int'(win_gray[3]) + top);
                mag = gx * gx + gy * gy;
                t1 = thresh_reg + 1;
                if (thresh_reg != THRESHOLD_OFF && mag >= t1 * t1) begin
                    res.edge_value = EDGE_ON;
                end
            end
            res.center_column = 11'(c - 1);
            res.center_row    = 11'(r - 1);
            res.frame_done    = last_col && last_row;
            expected_edges.push_back(res);
        end
        row_two_gray[idx] = 8'(mid);
        row_one_gray[idx] = 8'(bot);
        win_gray[0] = win_gray[3];
        win_gray[1] = win_gray[4];
        win_gray[2] = win_gray[5];
        win_gray[3] = 8'(top);
        win_gray[4] = 8'(mid);
        win_gray[5] = 8'(bot);
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            width_reg  = RST_FRAME_WIDTH;
            height_reg = RST_FRAME_HEIGHT;
            thresh_reg = RST_THRESHOLD;
            for (int i = 0; i < MAX_WIDTH; i++) begin
                row_one_gray[i] = '0;
                row_two_gray[i] = '0;
            end
            for (int i = 0; i < 6; i++) begin
                win_gray[i] = '0;
            end
            col_pos = 0;
            row_pos = 0;
            o_mismatch_count = 0;
            expected_edges.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FRAME_WIDTH:    width_reg  = i_cfg_wdata;
                    CFG_FRAME_HEIGHT:   height_reg = i_cfg_wdata;
                    CFG_EDGE_THRESHOLD: thresh_reg = i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                got = i_res;
                if (expected_edges.size() == 0) begin
                    $error("result word with nothing expected: column %0d row %0d",
                           got.center_column, got.center_row);
                    o_mismatch_count++;
                end else begin
                    want = expected_edges.pop_front();
                    if (got.edge_value !== want.edge_value) begin
                        $error("edge_value: expected %0d, actual %0d",
                               want.edge_value, got.edge_value);
                        o_mismatch_count++;
                    end
                    if (got.center_column !== want.center_column) begin
                        $error("center_column: expected %0d, actual %0d",
                               want.center_column, got.center_column);
                        o_mismatch_count++;
                    end
                    if (got.center_row !== want.center_row) begin
                        $error("center_row: expected %0d, actual %0d",
                               want.center_row, got.center_row);
                        o_mismatch_count++;
                    end
                    if (got.frame_done !== want.frame_done) begin
                        $error("frame_done: expected %0d, actual %0d",
                               want.frame_done, got.frame_done);
                        o_mismatch_count++;
                    end
                end
            end
            if (i_pix_valid && i_pix_ready) begin
                predict_edge(i_pix);
            end
        end
        o_pending_count = expected_edges.size();
    end

endmodule

### tb/sv/sobel_edge_threshold_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sobel edge threshold testbench
// Streams RGB frames of many sizes, thresholds and contents into the block,
// with random gaps on both channels and one long output stall, and leaves
// prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module sobel_edge_threshold_top_tb;
    import sobet_pkg::*;

    typedef enum int {FILL_NOISE, FILL_STEP, FILL_RAMP} t_fill_mode;

    localparam int MAX_W      = 2048;
    localparam int MAX_H      = 2048;
    localparam int RAND_ITEMS = 800;

    localparam t_pixel WHITE = t_pixel'(24'hFFFFFF);
    localparam t_pixel BLACK = t_pixel'(24'h000000);
    localparam logic [23:0] CORNER_PIXELS [9] = '{
        24'hFF0000, 24'h00FF00, 24'h0000FF,
        24'hFFFFFF, 24'h000000, 24'hFFFFFF,
        24'h010101, 24'h808080, 24'hFEFEFE
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [11:0] cfg_wdata;

    int          send_idle_pct;
    int          recv_idle_pct;
    int          idle_phase;
    int          mismatch_cnt;
    int          pending_cnt;

    sobet_stream_if #(.T(t_pixel))  pixel_ch ();
    sobet_stream_if #(.T(t_result)) result_ch ();

    sobel_edge_threshold_top #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_pixel     (pixel_ch),
        .o_result    (result_ch)
    );

    sobel_edge_threshold_checker #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_wdata      (cfg_wdata),
        .i_pix_valid      (pixel_ch.valid),
        .i_pix_ready      (pixel_ch.ready),
        .i_pix            (pixel_ch.payload),
        .i_res_valid      (result_ch.valid),
        .i_res_ready      (result_ch.ready),
        .i_res            (result_ch.payload),
        .o_mismatch_count (mismatch_cnt),
        .o_pending_count  (pending_cnt)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("sobel_edge_threshold_top_tb: FAIL");
        $finish;
    end

    // hold off the result channel once for a long stretch while pixels and
    // results are both flowing in the pressure frame
    initial begin
        int   hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end else if (idle_phase == 3 && !hold_done && pixel_ch.valid
                         && result_ch.valid) begin
                hold_done = 1'b1;
                hold_left = 100;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_pixel(input t_pixel px);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge clk);
            pixel_ch.valid <= 1'b0;
        end
        @(negedge clk);
        pixel_ch.valid   <= 1'b1;
        pixel_ch.payload <= px;
        do @(posedge clk); while (!pixel_ch.ready);
    endtask

    task automatic settle();
        @(negedge clk);
        pixel_ch.valid <= 1'b0;
        wait (pending_cnt == 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic send_frame(input int w, input t_fill_mode mode, input int count);
        int     lo, hi, split_c, split_r, sx, sy, c, r, v;
        t_pixel px;
        lo      = $urandom_range(0, 255);
        hi      = $urandom_range(0, 255);
        split_c = $urandom_range(0, w);
        split_r = $urandom_range(0, 8);
        sx      = $urandom_range(0, 40);
        sy      = $urandom_range(0, 40);
        for (int i = 0; i < count; i++) begin
            c = i % w;
            r = i / w;
            case (mode)
                FILL_STEP: begin
                    v  = ((c >= split_c) ^ (r >= split_r)) ? hi : lo;
                    px = {8'(v), 8'(v ^ $urandom_range(0, 7)), 8'(v)};
                end
                FILL_RAMP: begin
                    v  = lo + sx * c + sy * r;
                    px = {8'(v), 8'(v), 8'(v)};
                end
                default: px = t_pixel'(24'($urandom));
            endcase
            send_pixel(px);
        end
    endtask

    initial begin
        int rand_items, w, h, reg_w, reg_h, phase;
        cfg_we           = 1'b0;
        cfg_idx          = CFG_FRAME_WIDTH;
        cfg_wdata        = '0;
        pixel_ch.valid   = 1'b0;
        pixel_ch.payload = '0;
        send_idle_pct    = 33;
        recv_idle_pct    = 48;
        idle_phase       = 0;
        rst_n            = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_FRAME_WIDTH, 12'd3);
        write_reg(CFG_FRAME_HEIGHT, 12'd3);
        write_reg(CFG_EDGE_THRESHOLD, 12'd0);
        for (int i = 0; i < 9; i++) begin
            send_pixel(t_pixel'(CORNER_PIXELS[i]));
        end
        settle();

        write_reg(CFG_FRAME_WIDTH, 12'd4);
        write_reg(CFG_EDGE_THRESHOLD, 12'd254);
        for (int i = 0; i < 12; i++) begin
            send_pixel((i % 4 < 2) ? WHITE : BLACK);
        end
        settle();

        // sizes below range clamp to three, threshold of all ones marks nothing
        write_reg(CFG_FRAME_WIDTH, 12'd0);
        write_reg(CFG_FRAME_HEIGHT, 12'd2);
        write_reg(CFG_EDGE_THRESHOLD, 12'hFFF);
        for (int i = 0; i < 9; i++) begin
            send_pixel(((i % 3 + i / 3) % 2) ? WHITE : BLACK);
        end
        settle();

        // shrink the frame mid-row so the current row and frame end early
        write_reg(CFG_FRAME_WIDTH, 12'd8);
        write_reg(CFG_FRAME_HEIGHT, 12'd6);
        write_reg(CFG_EDGE_THRESHOLD, 12'd40);
        send_frame(8, FILL_STEP, 29);
        settle();
        write_reg(CFG_FRAME_WIDTH, 12'd4);
        write_reg(CFG_FRAME_HEIGHT, 12'd3);
        send_frame(4, FILL_NOISE, 13);
        settle();

        w = 4;
        h = 3;
        rand_items = 0;
        while (rand_items < RAND_ITEMS) begin
            phase = (rand_items * 3) / RAND_ITEMS;
            if (phase >= 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (phase == 1) begin
                send_idle_pct = 48;
                recv_idle_pct = 33;
            end
            idle_phase = phase;
            if ($urandom_range(0, 3) != 0) begin
                settle();
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(3, 12);
                h = $urandom_range(3, 8);
                reg_w = (w == 3 && $urandom_range(0, 2) == 0) ? $urandom_range(0, 2) : w;
                reg_h = (h == 3 && $urandom_range(0, 2) == 0) ? $urandom_range(0, 2) : h;
                write_reg(CFG_FRAME_WIDTH, 12'(reg_w));
                write_reg(CFG_FRAME_HEIGHT, 12'(reg_h));
                write_reg(CFG_EDGE_THRESHOLD, 12'($urandom_range(0, 4095)));
            end
            send_frame(w, t_fill_mode'($urandom_range(0, 2)), w * h);
            rand_items += w * h;
        end
        settle();

        // keep offering pixels through the long output stall
        write_reg(CFG_FRAME_WIDTH, 12'd16);
        write_reg(CFG_FRAME_HEIGHT, 12'd8);
        write_reg(CFG_EDGE_THRESHOLD, 12'($urandom_range(0, 80)));
        idle_phase = 3;
        send_frame(16, FILL_RAMP, 16 * 8);
        settle();

        if (mismatch_cnt == 0) begin
            $display("sobel_edge_threshold_top_tb: PASS");
        end else begin
            $display("sobel_edge_threshold_top_tb: FAIL");
        end
        $finish;
    end

endmodule
